// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared constants for the throttle shaper
// Register indexes, battery thresholds and servo pulse constants.
// ----------------------------------------------------------------------------
package esc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_IDLE_BAND    = 3'd0,
    REG_LIMIT_LEVEL  = 3'd1,
    REG_FORWARD_GAIN = 3'd2,
    REG_REVERSE_GAIN = 3'd3,
    REG_FORWARD_MAX  = 3'd4,
    REG_REVERSE_MAX  = 3'd5,
    REG_SLEW_STEP    = 3'd6,
    REG_IDLE_TIMEOUT = 3'd7
  } reg_idx_t;

  // Battery hysteresis thresholds in percent
  localparam logic [6:0] BATT_LOW_PCT  = 7'd30;
  localparam logic [6:0] BATT_HIGH_PCT = 7'd60;

  // Servo pulse: base plus span scaled over the 16-bit drive range
  localparam logic [20:0] PULSE_BASE_NS = 21'd1000000;
  localparam logic [18:0] PULSE_SPAN_NS = 19'd500000;

  // Magnitude ceiling of the negative drive limit
  localparam logic [16:0] REV_LIMIT_CAP = 17'd32768;

  // Bits of the shared serial multiplier
  localparam int MUL_BITS = 16;
  localparam int ACC_BITS = 35;

endpackage

// ===== rtl/esc_throttle_shaper.sv =====
// ----------------------------------------------------------------------------
// esc_throttle_shaper: radio throttle command to drive level and servo pulse
// Deadband, idle sleep, wake delay, low-battery limit, Q15 scaling, clamp,
// slew limiting and pulse width conversion, one control tick per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one control tick per transfer. tdata = command[15:0],
//            link_alive[16], battery_percent[23:17].
//   out_*  : one result per tick. tdata = pulse_ns[20:0], motor_enable[21],
//            drive_out[37:22], power_limited[38].
//   cfg_*  : register writes (index, data), always ready; write only when
//            the block is idle.
// Sequence: deadband, sleep and limit logic settle at the input transfer,
// then the bit-serial multiplier does the Q15 scaling, clamp and slew
// follow in ST_SLEW, the multiplier works out the pulse width and ST_DONE
// loads the output register. The next tick is taken once the block is back
// in ST_IDLE. The shared one-bit-per-cycle multiplier paces each item; one
// item is in work at a time.
// Reset: registers return to their defaults, motor asleep, drive level 0.
// Stall: a result waits in the output register; the next tick is taken
// meanwhile, and its result is held back until the output is free.
// ----------------------------------------------------------------------------
module esc_throttle_shaper
  import esc_pkg::*;
#(
  parameter int START_DELAY_TICKS = 160
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // command[15:0], link_alive, battery_percent[6:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // pulse_ns[20:0], motor_enable, drive_out[15:0],
                                  // power_limited, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_SLEW, ST_MUL2, ST_DONE
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [14:0] idle_band_r, limit_level_r, forward_max_r, slew_step_r;
  logic [15:0] forward_gain_r, reverse_gain_r, reverse_max_r, idle_timeout_r;

  // Tick state
  logic              sleeping_r;
  logic [15:0]       quiet_r;
  logic [7:0]        wake_r;
  logic              limit_r;
  logic signed [15:0] drive_r;

  // Work registers
  logic              neg_r, scale_r;
  logic [16:0]       tmag_r;
  logic [15:0]       mpl_r;
  logic [18:0]       mcand_r;
  logic [ACC_BITS-1:0] acc_r;
  logic [3:0]        cnt_r;

  // Output register
  logic              out_valid_r;
  logic [39:0]       out_data_r;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Input fields
  logic signed [15:0] in_cmd;
  logic               in_link;
  logic [6:0]         in_batt;
  assign in_cmd  = in_tdata[15:0];
  assign in_link = in_tdata[16];
  assign in_batt = in_tdata[23:17];

  // Front stage: deadband, sleep timer, wake, limit, direction
  logic signed [16:0] cmd_s, band_s, lim_s, t_s, prev_mag;
  logic               is_idle, pre_sleep, pre_lim, pre_pos, pre_neg;
  logic [15:0]        pre_quiet, q_inc;
  logic [7:0]         wake_tmp, pre_wake;
  logic [16:0]        pre_mag;
  logic [15:0]        pre_over;

  always_comb begin
    cmd_s     = in_link ? 17'(in_cmd) : 17'sd0;
    band_s    = $signed({2'b00, idle_band_r});
    prev_mag  = drive_r[15] ? -17'(drive_r) : 17'(drive_r);
    is_idle   = (cmd_s >= -band_s) && (cmd_s <= band_s);
    pre_sleep = sleeping_r;
    pre_quiet = quiet_r;
    wake_tmp  = wake_r;
    q_inc     = (quiet_r != 16'hFFFF) ? quiet_r + 16'd1 : quiet_r;
    if (is_idle) begin
      cmd_s = 17'sd0;
      if (prev_mag > band_s) begin
        pre_quiet = 16'd0;
      end else if (q_inc > idle_timeout_r) begin
        pre_sleep = 1'b1;
        pre_quiet = 16'd0;
      end else begin
        pre_quiet = q_inc;
      end
    end else if (sleeping_r) begin
      pre_sleep = 1'b0;
      wake_tmp  = 8'(START_DELAY_TICKS);
    end
    // Battery hysteresis, then clamp
    pre_lim = limit_r;
    if (in_batt < BATT_LOW_PCT)  pre_lim = 1'b1;
    if (in_batt > BATT_HIGH_PCT) pre_lim = 1'b0;
    lim_s = $signed({2'b00, limit_level_r});
    t_s   = cmd_s;
    if (pre_lim) begin
      if (t_s > lim_s)  t_s = lim_s;
      if (t_s < -lim_s) t_s = -lim_s;
    end
    // Start delay forces a zero target
    pre_wake = wake_tmp;
    if (wake_tmp != 8'd0) begin
      t_s      = 17'sd0;
      pre_wake = wake_tmp - 8'd1;
    end
    pre_pos  = t_s > band_s;
    pre_neg  = t_s < -band_s;
    pre_mag  = t_s[16] ? 17'(-t_s) : 17'(t_s);
    pre_over = 16'(pre_mag - {2'b00, idle_band_r});
  end

  // Clamp and slew stage
  logic [20:0]        s_mag;
  logic signed [20:0] s_val, fmax_s, rmax_s, d_s, lo_s, hi_s, drv_s;
  logic [16:0]        rmax;
  logic [15:0]        drv_bias;

  always_comb begin
    s_mag  = scale_r ? 21'(idle_band_r) + 21'(acc_r[34:15]) : 21'(tmag_r);
    s_val  = neg_r ? -$signed(s_mag) : $signed(s_mag);
    rmax   = ({1'b0, reverse_max_r} > REV_LIMIT_CAP) ? REV_LIMIT_CAP
                                                     : {1'b0, reverse_max_r};
    fmax_s = $signed(21'(forward_max_r));
    rmax_s = $signed(21'(rmax));
    if (s_val > fmax_s)  s_val = fmax_s;
    if (s_val < -rmax_s) s_val = -rmax_s;
    d_s  = $signed({{5{drive_r[15]}}, drive_r});
    lo_s = d_s - $signed(21'(slew_step_r));
    hi_s = d_s + $signed(21'(slew_step_r));
    if (s_val < lo_s)      drv_s = lo_s;
    else if (s_val > hi_s) drv_s = hi_s;
    else                   drv_s = s_val;
    drv_bias = {~drv_s[15], drv_s[14:0]};
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_band_r    <= 15'd2621;
      limit_level_r  <= 15'd28835;
      forward_gain_r <= 16'd26001;
      reverse_gain_r <= 16'd27782;
      forward_max_r  <= 15'd26542;
      reverse_max_r  <= 16'd28180;
      slew_step_r    <= 15'd327;
      idle_timeout_r <= 16'd12000;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_IDLE_BAND:    idle_band_r    <= cfg_data[14:0];
        REG_LIMIT_LEVEL:  limit_level_r  <= cfg_data[14:0];
        REG_FORWARD_GAIN: forward_gain_r <= cfg_data;
        REG_REVERSE_GAIN: reverse_gain_r <= cfg_data;
        REG_FORWARD_MAX:  forward_max_r  <= cfg_data[14:0];
        REG_REVERSE_MAX:  reverse_max_r  <= cfg_data;
        REG_SLEW_STEP:    slew_step_r    <= cfg_data[14:0];
        REG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer, tick state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sleeping_r  <= 1'b1;
      quiet_r     <= 16'd0;
      wake_r      <= 8'd0;
      limit_r     <= 1'b0;
      drive_r     <= 16'sd0;
      out_valid_r <= 1'b0;
      cnt_r       <= 4'd0;
    end else begin
      // Drop the result once taken, unless a new one loads now
      if (out_valid_r && out_tready && (state_r != ST_DONE)) out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            sleeping_r <= pre_sleep;
            quiet_r    <= pre_quiet;
            wake_r     <= pre_wake;
            limit_r    <= pre_lim;
            neg_r      <= t_s[16];
            scale_r    <= pre_pos || pre_neg;
            tmag_r     <= pre_mag;
            mpl_r      <= pre_over;
            mcand_r    <= 19'(pre_neg ? reverse_gain_r : forward_gain_r);
            acc_r      <= '0;
            cnt_r      <= 4'd0;
            state_r    <= ST_MUL1;
          end
        end
        ST_MUL1, ST_MUL2: begin
          // Shift in one multiplier bit per cycle, MSB first
          acc_r <= {acc_r[ACC_BITS-2:0], 1'b0}
                   + (mpl_r[15] ? ACC_BITS'(mcand_r) : '0);
          mpl_r <= {mpl_r[14:0], 1'b0};
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == 4'(MUL_BITS - 1)) begin
            state_r <= (state_r == ST_MUL1) ? ST_SLEW : ST_DONE;
          end
        end
        ST_SLEW: begin
          drive_r <= drv_s[15:0];
          mpl_r   <= drv_bias;
          mcand_r <= PULSE_SPAN_NS;
          acc_r   <= '0;
          cnt_r   <= 4'd0;
          state_r <= ST_MUL2;
        end
        ST_DONE: begin
          // Hold until the output register is free
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {1'b0, limit_r, drive_r, ~sleeping_r,
                            sleeping_r ? 21'd0
                                       : PULSE_BASE_NS + 21'(acc_r[34:15])};
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== verif/esc_throttle_shaper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_throttle_shaper_tb: self-checking bench for the throttle shaper
// Drives control ticks and register writes, predicts every result from an
// internal model of the shaper and compares each output transfer in order.
// ----------------------------------------------------------------------------
module esc_throttle_shaper_tb;
  import esc_pkg::*;

  localparam int WAKE_DELAY = 160;

  typedef struct packed {
    logic [20:0] pulse_ns;
    logic        motor_enable;
    logic [15:0] drive_out;
    logic        power_limited;
  } tick_result_t;

  // Shaper model with a queue of pending results
  class shaper_scoreboard;
    int unsigned band, lim_lvl, fgain, rgain, fmax, rmax, slew, tmo;
    bit          asleep;
    int unsigned quiet, wake;
    bit          limiting;
    int          drive;
    tick_result_t pending[$];
    int          errors;

    function void init();
      band = 2621; lim_lvl = 28835; fgain = 26001; rgain = 27782;
      fmax = 26542; rmax = 28180; slew = 327; tmo = 12000;
      asleep = 1; quiet = 0; wake = 0; limiting = 0; drive = 0;
      errors = 0;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_IDLE_BAND:    band = v[14:0];
        REG_LIMIT_LEVEL:  lim_lvl = v[14:0];
        REG_FORWARD_GAIN: fgain = v;
        REG_REVERSE_GAIN: rgain = v;
        REG_FORWARD_MAX:  fmax = v[14:0];
        REG_REVERSE_MAX:  rmax = v;
        REG_SLEW_STEP:    slew = v[14:0];
        REG_IDLE_TIMEOUT: tmo = v;
        default: ;
      endcase
    endfunction

    function int scale_mag(int m, int unsigned g);
      longint over;
      over = m - int'(band);
      return int'(band) + int'((over * g) >>> 15);
    endfunction

    // Note an accepted tick and queue its result
    function void note_tick(logic [23:0] d);
      int cmd, t, prev_mag, rlim, lo, hi, lim;
      int unsigned q;
      longint p;
      tick_result_t r;
      cmd = $signed(d[15:0]);
      prev_mag = drive < 0 ? -drive : drive;
      if (!d[16]) cmd = 0;
      if (cmd >= -int'(band) && cmd <= int'(band)) begin
        cmd = 0;
        if (prev_mag > int'(band)) begin
          quiet = 0;
        end else begin
          q = quiet < 65535 ? quiet + 1 : 65535;
          if (q > tmo) begin
            asleep = 1;
            quiet = 0;
          end else begin
            quiet = q;
          end
        end
      end else if (asleep) begin
        asleep = 0;
        wake = WAKE_DELAY;
      end
      if (d[23:17] < BATT_LOW_PCT) limiting = 1;
      if (d[23:17] > BATT_HIGH_PCT) limiting = 0;
      if (limiting) begin
        lim = lim_lvl;
        if (cmd > lim) cmd = lim;
        if (cmd < -lim) cmd = -lim;
      end
      t = cmd;
      if (wake > 0) begin
        t = 0;
        wake--;
      end
      if (t > int'(band)) t = scale_mag(t, fgain);
      else if (t < -int'(band)) t = -scale_mag(-t, rgain);
      rlim = rmax > 32768 ? 32768 : rmax;
      if (t > int'(fmax)) t = fmax;
      if (t < -rlim) t = -rlim;
      lo = drive - int'(slew);
      hi = drive + int'(slew);
      if (t < lo) drive = lo;
      else if (t > hi) drive = hi;
      else drive = t;
      p = 1000000 + ((longint'(drive + 32768) * 500000) >>> 15);
      r.pulse_ns = asleep ? 21'd0 : p[20:0];
      r.motor_enable = !asleep;
      r.drive_out = drive[15:0];
      r.power_limited = limiting;
      pending.push_back(r);
    endfunction

    // Compare one output transfer with the oldest prediction
    function void check_result(logic [39:0] d);
      tick_result_t a, e;
      a = {d[20:0], d[21], d[37:22], d[38]};
      if (pending.size() == 0) begin
        $error("unexpected result %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.pulse_ns !== e.pulse_ns) begin
        $error("pulse_ns exp %0d got %0d", e.pulse_ns, a.pulse_ns); errors++;
      end
      if (a.motor_enable !== e.motor_enable) begin
        $error("motor_enable exp %0d got %0d", e.motor_enable, a.motor_enable);
        errors++;
      end
      if (a.drive_out !== e.drive_out) begin
        $error("drive_out exp %0d got %0d", $signed(e.drive_out),
               $signed(a.drive_out));
        errors++;
      end
      if (a.power_limited !== e.power_limited) begin
        $error("power_limited exp %0d got %0d", e.power_limited, a.power_limited);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  bit          sink_on = 0;

  shaper_scoreboard sb;

  always #5 clk = ~clk;

  esc_throttle_shaper u_top (.*);

  // Check each output transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Receiver with random stalls
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (sink_on && out_tvalid && out_tready) begin
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
          out_tready <= 0;
          repeat (gap) @(posedge clk);
        end
        out_tready <= 1;
      end else if (sink_on) begin
        out_tready <= 1;
      end
    end
  end

  // Valid stays high into the next tick when no idle gap is drawn
  task automatic send_tick(logic [15:0] cmd, logic link, logic [6:0] batt,
                           bit no_gap = 1'b0);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= {batt, link, cmd};
    do @(posedge clk); while (!in_tready);
    sb.note_tick({batt, link, cmd});
  endtask

  task automatic write_reg(reg_idx_t idx, logic [15:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic random_ticks(int n);
    logic [15:0] c;
    logic [6:0]  b;
    repeat (n) begin
      c = $urandom_range(0, 3) == 0 ? 16'($urandom_range(0, 4000) - 2000)
                                    : 16'($urandom);
      b = $urandom_range(0, 9) == 0 ? 7'($urandom_range(0, 127))
                                    : 7'($urandom_range(0, 100));
      send_tick(c, $urandom_range(0, 9) != 0, b, $urandom_range(0, 4) == 0);
    end
  endtask

  initial begin
    sb = new();
    sb.init();
    repeat (11) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    sink_on = 1;

    // Directed: extremes, deadband, link loss, battery hysteresis, wake delay
    send_tick(16'h0000, 1'b1, 7'd100);
    send_tick(16'h7fff, 1'b1, 7'd100);
    send_tick(16'h8000, 1'b1, 7'd100);
    send_tick(16'h7fff, 1'b0, 7'd100);
    send_tick(16'd2621, 1'b1, 7'd50);
    send_tick(-16'sd2621, 1'b1, 7'd50);
    send_tick(16'd2622, 1'b1, 7'd29);
    send_tick(16'h7fff, 1'b1, 7'd45);
    send_tick(16'h8000, 1'b1, 7'd61);
    send_tick(16'h7fff, 1'b1, 7'd127);
    send_tick(16'h1234, 1'b1, 7'd0);
    repeat (170) send_tick(16'h7fff, 1'b1, 7'd100, 1'b1);
    repeat (10) send_tick(16'h8000, 1'b1, 7'd100, 1'b1);
    drain();

    // Extreme settings: huge gains, full reverse cap, largest slew step, short timeout
    write_reg(REG_IDLE_BAND, 16'd0);
    write_reg(REG_LIMIT_LEVEL, 16'd32767);
    write_reg(REG_FORWARD_GAIN, 16'd32768);
    write_reg(REG_REVERSE_GAIN, 16'hffff);
    write_reg(REG_FORWARD_MAX, 16'd32767);
    write_reg(REG_REVERSE_MAX, 16'hffff);
    write_reg(REG_SLEW_STEP, 16'd32767);
    write_reg(REG_IDLE_TIMEOUT, 16'd3);
    random_ticks(250);
    drain();

    write_reg(REG_IDLE_BAND, 16'h7fff);
    write_reg(REG_SLEW_STEP, 16'd0);
    write_reg(REG_IDLE_TIMEOUT, 16'hffff);
    write_reg(REG_LIMIT_LEVEL, 16'd0);
    write_reg(REG_FORWARD_MAX, 16'd0);
    write_reg(REG_REVERSE_MAX, 16'd0);
    random_ticks(100);
    drain();

    // Random mid-range settings
    repeat (3) begin
      write_reg(REG_IDLE_BAND, 16'($urandom_range(0, 4000)));
      write_reg(REG_LIMIT_LEVEL, 16'($urandom_range(0, 32767)));
      write_reg(REG_FORWARD_GAIN, 16'($urandom_range(0, 32768)));
      write_reg(REG_REVERSE_GAIN, 16'($urandom_range(0, 32768)));
      write_reg(REG_FORWARD_MAX, 16'($urandom_range(0, 32767)));
      write_reg(REG_REVERSE_MAX, 16'($urandom_range(0, 32768)));
      write_reg(REG_SLEW_STEP, 16'($urandom_range(1, 8000)));
      write_reg(REG_IDLE_TIMEOUT, 16'($urandom_range(0, 40)));
      random_ticks(200);
      drain();
    end

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end

endmodule
